[design/ycc411_pkg.sv]
// shared types, constants and helpers for the rgb to ycbcr 4:1:1 subsampler
package ycc411_pkg;

    localparam int ROW_WIDTH      = 720;
    localparam int DECIMATION     = 4;
    localparam int PIX_FRAC       = 12;
    localparam int TAPS           = 7;
    localparam int HALF_TAPS      = 3;
    localparam int PIX_W          = 13;
    localparam int COL_W          = 10;
    localparam int WGT_W          = 16;
    localparam int WIN_W          = 30;
    localparam int PROD_W         = WIN_W + WGT_W + 1;
    localparam int SUM_W          = 48;
    localparam int SCL_W          = 40;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int IN_DATA_W      = 40;
    localparam int OUT_DATA_W     = 40;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_COL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_CENTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W_ONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W_TWO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_W_THREE   = 3'd5;

    localparam logic SAMPLE_LUMA   = 1'b0;
    localparam logic SAMPLE_CHROMA = 1'b1;

    // control and broadcast data shared by every window cell
    typedef struct packed {
        logic             push;
        logic             clear;
        logic             prod_en;
        logic [COL_W-1:0] column;
        logic [1:0]       phase;
        logic [COL_W-1:0] first_col;
        logic [WGT_W-1:0] w_center;
        logic [WGT_W-1:0] w_one;
        logic [WGT_W-1:0] w_two;
        logic [WGT_W-1:0] w_three;
    } t_tap_ctl;

    // floor(x / 2^28) + 128, saturated to a byte
    function automatic logic [7:0] chroma_byte(input logic signed [SCL_W-1:0] x);
        logic signed [SCL_W-29:0] s;
        logic signed [SCL_W-28:0] v;
        s = x[SCL_W-1:28];
        v = {s[SCL_W-29], s} + (SCL_W-27)'(128);
        if (v < 0) begin
            chroma_byte = 8'd0;
        end else if (v > (SCL_W-27)'(255)) begin
            chroma_byte = 8'd255;
        end else begin
            chroma_byte = v[7:0];
        end
    endfunction

endpackage

[design/ycc411_cell.sv]
// one cell of the chroma window: holds a cb/cr pair and adds its weighted tap to a running sum
module ycc411_cell #(
    parameter int IDX = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ycc411_pkg::t_tap_ctl                 i_ctl,
    input  logic signed [ycc411_pkg::WIN_W-1:0]  i_cb,
    input  logic signed [ycc411_pkg::WIN_W-1:0]  i_cr,
    output logic signed [ycc411_pkg::WIN_W-1:0]  o_cb,
    output logic signed [ycc411_pkg::WIN_W-1:0]  o_cr,
    input  logic signed [ycc411_pkg::SUM_W-1:0]  i_sum_cb,
    input  logic signed [ycc411_pkg::SUM_W-1:0]  i_sum_cr,
    output logic signed [ycc411_pkg::SUM_W-1:0]  o_sum_cb,
    output logic signed [ycc411_pkg::SUM_W-1:0]  o_sum_cr
);
    import ycc411_pkg::*;

    logic signed [WIN_W-1:0]  r_cb, r_cr;
    logic signed [PROD_W-1:0] r_prod_cb, r_prod_cr;
    logic signed [SUM_W-1:0]  r_sum_cb, r_sum_cr;
    logic signed [4:0]        tap_ofs;
    logic [2:0]               adist;
    logic [COL_W:0]           min_col;
    logic                     take;
    logic [WGT_W-1:0]         wgt;

    // offset of this tap from the chroma centre
    always_comb begin
        tap_ofs = $signed({3'b0, i_ctl.phase}) - 5'(IDX);
        adist   = tap_ofs[4] ? 3'(-tap_ofs) : tap_ofs[2:0];
        min_col = {1'b0, i_ctl.first_col} + (COL_W+1)'(IDX);
        take    = (tap_ofs >= -5'sd3) && (tap_ofs <= 5'sd3)
                  && ({1'b0, i_ctl.column} >= min_col);
        case (adist)
            3'd0:    wgt = i_ctl.w_center;
            3'd1:    wgt = i_ctl.w_one;
            3'd2:    wgt = i_ctl.w_two;
            default: wgt = i_ctl.w_three;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cb <= '0;
            r_cr <= '0;
        end else if (i_ctl.clear) begin
            r_cb <= '0;
            r_cr <= '0;
        end else if (i_ctl.push) begin
            r_cb <= i_cb;
            r_cr <= i_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            if (take) begin
                r_prod_cb <= r_cb * $signed({1'b0, wgt});
                r_prod_cr <= r_cr * $signed({1'b0, wgt});
            end else begin
                r_prod_cb <= '0;
                r_prod_cr <= '0;
            end
        end
        r_sum_cb <= i_sum_cb + SUM_W'(r_prod_cb);
        r_sum_cr <= i_sum_cr + SUM_W'(r_prod_cr);
    end

    assign o_cb     = r_cb;
    assign o_cr     = r_cr;
    assign o_sum_cb = r_sum_cb;
    assign o_sum_cr = r_sum_cr;

endmodule

[design/rgb_to_ycbcr_411_subsampler_unit.sv]
// top level: rec.709 rgb to studio ycbcr with 4:1:1 chroma through a row of window cells
//
//  channel  | direction | handshake                   | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata rgb, tlast end_of_row
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata col/y/cb/cr, tuser kind, tlast
//  cfg      | in        | i_cfg_valid/o_cfg_ready     | i_cfg_index, i_cfg_data
//
// one pixel at a time: a luma-only pixel passes the matrix, push, product and luma states,
// the last giving the luma beat; a pixel with chroma also runs the 7-cell sum chain and a
// scale state before its luma and chroma beats
// synchronous active-low reset clears window, column counter, state; sets config defaults
// a stalled output beat holds the block; no pixel is taken until all beats are gone
module rgb_to_ycbcr_411_subsampler_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [12:0] red, [25:13] green, [38:26] blue, [39] zero
    input  logic [ycc411_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [9:0] column, [17:10] luma_byte, [25:18] cb_byte, [33:26] cr_byte, [39:34] zero
    output logic [ycc411_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] sample_kind
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ycc411_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ycc411_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ycc411_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MAT, S_PUSH, S_PROD, S_CHAIN, S_SCALE, S_LUMA, S_CHROMA
    } t_state;

    t_state r_state;
    logic [2:0] r_cnt;

    logic [COL_W-1:0] r_first, r_last, r_col_cnt, r_col;
    logic [WGT_W-1:0] r_w0, r_w1, r_w2, r_w3;
    logic [PIX_W-1:0] r_r, r_g, r_b;
    logic             r_row_end, r_chroma;
    logic [28:0]      r_y;
    logic signed [WIN_W-1:0] r_cbv, r_crv;
    logic [7:0]       r_luma;
    logic signed [SCL_W-1:0] r_sc_cb, r_sc_cr;

    logic [PIX_W-1:0] n_r, n_g, n_b;
    logic             n_row_end;
    logic [COL_W-1:0] pix_col;
    logic [36:0]      y219;
    logic signed [30:0] rs, gs, bs, cb_full, cr_full;
    logic signed [SUM_W-1:0] t_cb, t_cr;
    logic             out_beat, done;
    logic [7:0]       cb_byte, cr_byte;

    t_tap_ctl ctl;
    logic signed [WIN_W-1:0] win_cb [TAPS+1];
    logic signed [WIN_W-1:0] win_cr [TAPS+1];
    logic signed [SUM_W-1:0] sum_cb [TAPS+1];
    logic signed [SUM_W-1:0] sum_cr [TAPS+1];

    function automatic logic [PIX_W-1:0] clamp(input logic [PIX_W-1:0] v);
        clamp = (v > PIX_W'(1 << PIX_FRAC)) ? PIX_W'(1 << PIX_FRAC) : v;
    endfunction

    assign n_r       = clamp(s_axis_tdata[12:0]);
    assign n_g       = clamp(s_axis_tdata[25:13]);
    assign n_b       = clamp(s_axis_tdata[38:26]);
    assign n_row_end = s_axis_tlast || (r_col_cnt >= r_last)
                       || (r_col_cnt >= COL_W'(ROW_WIDTH - 1));

    assign rs = $signed({18'b0, r_r});
    assign gs = $signed({18'b0, r_g});
    assign bs = $signed({18'b0, r_b});
    assign cb_full = 31'sd32768 * bs - 31'sd7509 * rs - 31'sd25259 * gs;
    assign cr_full = 31'sd32768 * rs - 31'sd29763 * gs - 31'sd3005 * bs;
    assign y219    = 37'(r_y) * 37'd219;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign out_beat      = m_axis_tvalid && m_axis_tready;
    assign done = out_beat && (r_state == S_CHROMA || (r_state == S_LUMA && !r_chroma));

    // floor to q.(f+16) before the 224 scaling
    assign t_cb = sum_cb[TAPS] >>> 16;
    assign t_cr = sum_cr[TAPS] >>> 16;
    assign cb_byte = chroma_byte(r_sc_cb);
    assign cr_byte = chroma_byte(r_sc_cr);

    always_comb begin
        ctl.push      = (r_state == S_PUSH);
        ctl.clear     = done && r_row_end;
        ctl.prod_en   = (r_state == S_PROD);
        ctl.column    = r_col;
        ctl.phase     = r_col[1:0];
        ctl.first_col = r_first;
        ctl.w_center  = r_w0;
        ctl.w_one     = r_w1;
        ctl.w_two     = r_w2;
        ctl.w_three   = r_w3;
    end

    assign win_cb[0] = r_cbv;
    assign win_cr[0] = r_crv;
    assign sum_cb[0] = '0;
    assign sum_cr[0] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        ycc411_cell #(.IDX(k)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_cb     (win_cb[k]),
            .i_cr     (win_cr[k]),
            .o_cb     (win_cb[k+1]),
            .o_cr     (win_cr[k+1]),
            .i_sum_cb (sum_cb[k]),
            .i_sum_cr (sum_cr[k]),
            .o_sum_cb (sum_cb[k+1]),
            .o_sum_cr (sum_cr[k+1])
        );
    end

    always_comb begin
        m_axis_tvalid = (r_state == S_LUMA) || (r_state == S_CHROMA);
        m_axis_tdata  = '0;
        if (r_state == S_CHROMA) begin
            m_axis_tuser       = SAMPLE_CHROMA;
            m_axis_tlast       = 1'b1;
            m_axis_tdata[9:0]  = {2'b0, r_col[COL_W-1:2]};
            m_axis_tdata[25:18] = cb_byte;
            m_axis_tdata[33:26] = cr_byte;
        end else begin
            m_axis_tuser       = SAMPLE_LUMA;
            m_axis_tlast       = !r_chroma;
            m_axis_tdata[9:0]  = r_col;
            m_axis_tdata[17:10] = r_luma;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 10'd0;
            r_last  <= 10'd719;
            r_w0    <= 16'd16384;
            r_w1    <= 16'd12288;
            r_w2    <= 16'd8192;
            r_w3    <= 16'd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FIRST_COL: r_first <= i_cfg_data[COL_W-1:0];
                REG_LAST_COL:  r_last  <= i_cfg_data[COL_W-1:0];
                REG_W_CENTER:  r_w0    <= i_cfg_data;
                REG_W_ONE:     r_w1    <= i_cfg_data;
                REG_W_TWO:     r_w2    <= i_cfg_data;
                REG_W_THREE:   r_w3    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_col_cnt <= 10'd0;
            r_row_end <= 1'b0;
            r_chroma  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_r       <= n_r;
                        r_g       <= n_g;
                        r_b       <= n_b;
                        r_col     <= r_col_cnt;
                        r_row_end <= n_row_end;
                        r_chroma  <= n_row_end || (r_col_cnt[1:0] == 2'(DECIMATION - 1));
                        r_col_cnt <= n_row_end ? r_first : r_col_cnt + 10'd1;
                        r_state   <= S_MAT;
                    end
                end
                S_MAT: begin
                    r_y     <= 29'(r_r) * 29'd13933 + 29'(r_g) * 29'd46871
                               + 29'(r_b) * 29'd4732;
                    r_cbv   <= WIN_W'(cb_full);
                    r_crv   <= WIN_W'(cr_full);
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    r_luma  <= 8'(y219[36:28] + 9'd16);
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_cnt   <= '0;
                    r_state <= r_chroma ? S_CHAIN : S_LUMA;
                end
                S_CHAIN: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'(TAPS - 1)) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_sc_cb <= SCL_W'(t_cb) * SCL_W'(224);
                    r_sc_cr <= SCL_W'(t_cr) * SCL_W'(224);
                    r_state <= S_LUMA;
                end
                S_LUMA: begin
                    if (m_axis_tready) begin
                        r_state <= r_chroma ? S_CHROMA : S_IDLE;
                    end
                end
                S_CHROMA: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
